FILE: hdl/hrp_pkg.sv
`timescale 1ns / 1ps

package hrp_pkg;

    localparam int LenWidth = 32;
    localparam int OutLenWidth = 32;
    localparam int StatusWidth = 16;
    localparam int QDepth = 4;
    localparam int QAddrW = $clog2(QDepth);
    localparam int QCountW = $clog2(QDepth + 1);
    localparam int PosW = 5;
    localparam logic [PosW-1:0] PosMax = '1;
    localparam int PfxShort = 5;
    localparam int PfxLong = 15;
    localparam logic [StatusWidth-1:0] StatusMinReset = 16'd500;

    localparam logic [7:0] HttpText [PfxShort] = '{"H", "T", "T", "P", "/"};
    localparam logic [7:0] LowerText [PfxLong] = '{
        "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h", ":"
    };
    localparam logic [7:0] UpperText [PfxLong] = '{
        "C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t", "h", ":"
    };

    typedef enum logic [1:0] {
        MODE_HEADER,
        MODE_BODY,
        MODE_ERROR,
        MODE_DONE
    } t_mode;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_HDR_END = 3'd1,
        KIND_BODY    = 3'd2,
        KIND_LAST    = 3'd3,
        KIND_ERROR   = 3'd4,
        KIND_IGNORED = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        SPH_PRE,
        SPH_SKIP,
        SPH_DIGITS,
        SPH_DONE
    } t_sphase;

    typedef enum logic [1:0] {
        LPH_SKIP,
        LPH_DIGITS,
        LPH_DONE
    } t_lphase;

    typedef struct packed {
        logic [7:0]          data;
        logic                sor;
        logic                is_nl;
        logic                is_cr;
        logic                is_zero;
        logic                is_space;
        logic                is_ws;
        logic                is_plus;
        logic                is_minus;
        logic                is_digit;
        logic [3:0]          digit;
        logic [PfxShort-1:0] m_http;
        logic [PfxLong-1:0]  m_lower;
        logic [PfxLong-1:0]  m_upper;
    } t_item;

    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             data;
        logic [StatusWidth-1:0] status;
        logic [OutLenWidth-1:0] length;
    } t_result;

    function automatic logic [OutLenWidth-1:0] sat_len(input logic [LenWidth-1:0] v);
        logic [LenWidth-1:0] upper;
        upper = v >> OutLenWidth;
        if (upper != '0) begin
            return '1;
        end
        return OutLenWidth'(v);
    endfunction

endpackage

FILE: hdl/http_response_header_parser.sv
`timescale 1ns / 1ps
// Each byte passes the front register and queue; its registered result waits for the sink.
// Throughput: one byte per cycle while the queue is not full; the back end updates per byte.
// A four-entry queue between classifier and parser absorbs short output stalls.
// Reset is synchronous and active low; it clears all parser state and sets the threshold to 500.
module http_response_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_response,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_byte_out,
    output logic [15:0] o_status_code,
    output logic [31:0] o_body_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import hrp_pkg::*;

    logic [StatusWidth-1:0] r_error_status_min;
    logic                   fr_valid;
    t_item                  fr_item;
    logic                   q_full;
    logic                   q_valid;
    t_item                  q_item;
    logic                   q_pop;
    t_result                result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_status_min <= StatusMinReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_error_status_min <= i_cfg_data;
        end
    end

    hrp_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_data_byte         (i_data_byte),
        .i_start_of_response (i_start_of_response),
        .i_queue_full        (q_full),
        .o_item_valid        (fr_valid),
        .o_item              (fr_item)
    );

    hrp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fr_valid),
        .i_push_item (fr_item),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_item      (q_item)
    );

    hrp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item_valid       (q_valid),
        .i_item             (q_item),
        .o_pop              (q_pop),
        .i_error_status_min (r_error_status_min),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_result           (result)
    );

    assign o_kind        = result.kind;
    assign o_byte_out    = result.data;
    assign o_status_code = result.status;
    assign o_body_length = result.length;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fr_valid && q_full |=> fr_valid)
        else $error("front beat lost while queue full");

    a_error_over_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_ERROR |-> o_status_code >= r_error_status_min)
        else $error("server error reported below threshold");

endmodule

FILE: hdl/hrp_front.sv
`timescale 1ns / 1ps

module hrp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [7:0]    i_data_byte,
    input  logic          i_start_of_response,
    input  logic          i_queue_full,
    output logic          o_item_valid,
    output hrp_pkg::t_item o_item
);
    import hrp_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  load;
    logic  push;

    always_comb begin
        n_item          = '0;
        n_item.data     = i_data_byte;
        n_item.sor      = i_start_of_response;
        n_item.is_nl    = i_data_byte == 8'h0A;
        n_item.is_cr    = i_data_byte == 8'h0D;
        n_item.is_zero  = i_data_byte == 8'h00;
        n_item.is_space = i_data_byte == " ";
        n_item.is_ws    = (i_data_byte == " ") ||
                          (i_data_byte >= 8'd9 && i_data_byte <= 8'd13);
        n_item.is_plus  = i_data_byte == "+";
        n_item.is_minus = i_data_byte == "-";
        n_item.is_digit = i_data_byte >= "0" && i_data_byte <= "9";
        n_item.digit    = 4'(i_data_byte - "0");
        for (int k = 0; k < PfxShort; k++) begin
            n_item.m_http[k] = i_data_byte == HttpText[k];
        end
        for (int k = 0; k < PfxLong; k++) begin
            n_item.m_lower[k] = i_data_byte == LowerText[k];
            n_item.m_upper[k] = i_data_byte == UpperText[k];
        end
    end

    assign push       = r_valid && !i_queue_full;
    assign o_in_stall = r_valid && i_queue_full;
    assign load       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

FILE: hdl/hrp_queue.sv
`timescale 1ns / 1ps

module hrp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hrp_pkg::t_item i_push_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output hrp_pkg::t_item o_item
);
    import hrp_pkg::*;

    t_item              r_mem [QDepth];
    logic [QAddrW-1:0]  r_wr;
    logic [QAddrW-1:0]  r_rd;
    logic [QCountW-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = r_count == QCountW'(QDepth);
    assign o_valid = r_count != '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= QAddrW'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= QAddrW'(r_rd + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= QCountW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= QCountW'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

FILE: hdl/hrp_back.sv
`timescale 1ns / 1ps

module hrp_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_item_valid,
    input  hrp_pkg::t_item                     i_item,
    output logic                               o_pop,
    input  logic [hrp_pkg::StatusWidth-1:0]    i_error_status_min,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output hrp_pkg::t_result                   o_result
);
    import hrp_pkg::*;

    localparam int AccW = LenWidth + 4;
    localparam int SAccW = StatusWidth + 4;

    t_mode                  r_mode, n_mode, c_mode;
    logic [PosW-1:0]        r_pos, n_pos, c_pos;
    logic [2:0]             r_pm, n_pm, c_pm;
    logic                   r_cut, n_cut, c_cut;
    logic                   r_fcr, n_fcr, c_fcr;
    t_sphase                r_sph, n_sph, c_sph;
    logic                   r_sneg, n_sneg, c_sneg;
    logic [StatusWidth-1:0] r_sacc, n_sacc, c_sacc;
    t_lphase                r_lph, n_lph, c_lph;
    logic                   r_lneg, n_lneg, c_lneg;
    logic [LenWidth-1:0]    r_lacc, n_lacc, c_lacc;
    logic [StatusWidth-1:0] r_sstat, n_sstat, c_sstat;
    logic [LenWidth-1:0]    r_slen, n_slen, c_slen;
    logic [LenWidth-1:0]    r_bcnt, n_bcnt, c_bcnt;
    t_kind                  kind;
    logic                   r_out_valid;
    t_result                r_result;
    logic                   take;
    logic                   cut;
    logic [SAccW-1:0]       s_next;
    logic [AccW-1:0]        l_next;
    logic [StatusWidth-1:0] st;
    logic                   hit_http, hit_lower, hit_upper;

    assign take  = i_item_valid && (!r_out_valid || !i_out_stall);
    assign o_pop = take;

    always_comb begin
        c_mode  = r_mode;
        c_pos   = r_pos;
        c_pm    = r_pm;
        c_cut   = r_cut;
        c_fcr   = r_fcr;
        c_sph   = r_sph;
        c_sneg  = r_sneg;
        c_sacc  = r_sacc;
        c_lph   = r_lph;
        c_lneg  = r_lneg;
        c_lacc  = r_lacc;
        c_sstat = r_sstat;
        c_slen  = r_slen;
        c_bcnt  = r_bcnt;
        if (i_item.sor) begin
            c_mode  = MODE_HEADER;
            c_pos   = '0;
            c_pm    = 3'b111;
            c_cut   = 1'b0;
            c_fcr   = 1'b0;
            c_sph   = SPH_PRE;
            c_sneg  = 1'b0;
            c_sacc  = '0;
            c_lph   = LPH_SKIP;
            c_lneg  = 1'b0;
            c_lacc  = '0;
            c_sstat = '0;
            c_slen  = '0;
            c_bcnt  = '0;
        end

        n_mode  = c_mode;
        n_pos   = c_pos;
        n_pm    = c_pm;
        n_cut   = c_cut;
        n_fcr   = c_fcr;
        n_sph   = c_sph;
        n_sneg  = c_sneg;
        n_sacc  = c_sacc;
        n_lph   = c_lph;
        n_lneg  = c_lneg;
        n_lacc  = c_lacc;
        n_sstat = c_sstat;
        n_slen  = c_slen;
        n_bcnt  = c_bcnt;
        kind    = KIND_HEADER;

        cut       = c_cut || i_item.is_zero;
        hit_http  = (c_pos < PosW'(PfxShort)) ? i_item.m_http[c_pos[2:0]] : 1'b0;
        hit_lower = (c_pos < PosW'(PfxLong)) ? i_item.m_lower[c_pos[3:0]] : 1'b0;
        hit_upper = (c_pos < PosW'(PfxLong)) ? i_item.m_upper[c_pos[3:0]] : 1'b0;
        s_next    = SAccW'(c_sacc) * SAccW'(10) + SAccW'(i_item.digit);
        l_next    = AccW'(c_lacc) * AccW'(10) + AccW'(i_item.digit);
        st        = c_sneg ? '0 : c_sacc;

        case (c_mode)
            MODE_HEADER: begin
                if (i_item.is_nl) begin
                    if (c_pm[0] && c_pos >= PosW'(PfxShort)) begin
                        n_sstat = st;
                        if (st >= i_error_status_min) begin
                            n_mode = MODE_ERROR;
                            kind   = KIND_ERROR;
                        end
                    end else if ((c_pm[1] || c_pm[2]) && c_pos >= PosW'(PfxLong)) begin
                        n_slen = c_lneg ? '0 : c_lacc;
                    end
                    if (kind != KIND_ERROR && c_fcr) begin
                        n_mode = MODE_BODY;
                        kind   = KIND_HDR_END;
                    end
                    n_pos  = '0;
                    n_pm   = 3'b111;
                    n_cut  = 1'b0;
                    n_fcr  = 1'b0;
                    n_sph  = SPH_PRE;
                    n_sneg = 1'b0;
                    n_sacc = '0;
                    n_lph  = LPH_SKIP;
                    n_lneg = 1'b0;
                    n_lacc = '0;
                end else begin
                    n_cut = cut;
                    if (c_pos < PosW'(PfxShort) && (cut || !hit_http)) begin
                        n_pm[0] = 1'b0;
                    end
                    if (c_pos < PosW'(PfxLong) && (cut || !hit_lower)) begin
                        n_pm[1] = 1'b0;
                    end
                    if (c_pos < PosW'(PfxLong) && (cut || !hit_upper)) begin
                        n_pm[2] = 1'b0;
                    end
                    if (c_pos == PosW'(0) && i_item.is_cr) begin
                        n_fcr = 1'b1;
                    end
                    if (c_pos == PosW'(1) && !i_item.is_zero) begin
                        n_fcr = 1'b0;
                    end
                    if (!cut) begin
                        case (c_sph)
                            SPH_PRE: begin
                                if (i_item.is_space) begin
                                    n_sph = SPH_SKIP;
                                end
                            end
                            SPH_SKIP, SPH_DIGITS: begin
                                if (c_sph == SPH_SKIP && i_item.is_ws) begin
                                    n_sph = SPH_SKIP;
                                end else if (c_sph == SPH_SKIP &&
                                             (i_item.is_plus || i_item.is_minus)) begin
                                    n_sneg = i_item.is_minus;
                                    n_sph  = SPH_DIGITS;
                                end else if (i_item.is_digit) begin
                                    n_sacc = (s_next[SAccW-1:StatusWidth] != '0) ?
                                             '1 : StatusWidth'(s_next);
                                    n_sph  = SPH_DIGITS;
                                end else begin
                                    n_sph = SPH_DONE;
                                end
                            end
                            default: begin
                                n_sph = SPH_DONE;
                            end
                        endcase
                        if (c_pos >= PosW'(PfxLong)) begin
                            if (c_lph == LPH_SKIP && i_item.is_ws) begin
                                n_lph = LPH_SKIP;
                            end else if (c_lph == LPH_SKIP &&
                                         (i_item.is_plus || i_item.is_minus)) begin
                                n_lneg = i_item.is_minus;
                                n_lph  = LPH_DIGITS;
                            end else if ((c_lph == LPH_SKIP || c_lph == LPH_DIGITS) &&
                                         i_item.is_digit) begin
                                n_lacc = (l_next[AccW-1:LenWidth] != '0) ?
                                         '1 : LenWidth'(l_next);
                                n_lph  = LPH_DIGITS;
                            end else begin
                                n_lph = LPH_DONE;
                            end
                        end
                    end
                    if (c_pos != PosMax) begin
                        n_pos = PosW'(c_pos + 1'b1);
                    end
                end
            end
            MODE_BODY: begin
                if (c_bcnt != '1) begin
                    n_bcnt = LenWidth'(c_bcnt + 1'b1);
                end
                if (n_bcnt >= c_slen) begin
                    kind   = KIND_LAST;
                    n_mode = MODE_DONE;
                end else begin
                    kind = KIND_BODY;
                end
            end
            default: begin
                kind = KIND_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HEADER;
            r_pos   <= '0;
            r_pm    <= 3'b111;
            r_cut   <= 1'b0;
            r_fcr   <= 1'b0;
            r_sph   <= SPH_PRE;
            r_sneg  <= 1'b0;
            r_sacc  <= '0;
            r_lph   <= LPH_SKIP;
            r_lneg  <= 1'b0;
            r_lacc  <= '0;
            r_sstat <= '0;
            r_slen  <= '0;
            r_bcnt  <= '0;
        end else if (take) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_pm    <= n_pm;
            r_cut   <= n_cut;
            r_fcr   <= n_fcr;
            r_sph   <= n_sph;
            r_sneg  <= n_sneg;
            r_sacc  <= n_sacc;
            r_lph   <= n_lph;
            r_lneg  <= n_lneg;
            r_lacc  <= n_lacc;
            r_sstat <= n_sstat;
            r_slen  <= n_slen;
            r_bcnt  <= n_bcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result.kind   <= kind;
            r_result.data   <= i_item.data;
            r_result.status <= n_sstat;
            r_result.length <= sat_len(n_slen);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

FILE: tb/sv/http_response_header_parser_tb.sv
`timescale 1ns / 1ps

module http_response_header_parser_tb;
    import hrp_pkg::*;

    localparam int CycleLimit = 500000;
    localparam int DirRows = 26;
    localparam int Phases = 6;
    localparam int PhaseBeats = 200;

    typedef struct packed {
        logic        sor;
        logic [7:0]  data;
        logic        typed;
        t_kind       kind;
        logic [15:0] status;
        logic [31:0] length;
    } t_step_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_start_of_response = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_byte_out;
    logic [15:0] o_status_code;
    logic [31:0] o_body_length;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 16'h0000;

    http_response_header_parser u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_data_byte         (i_data_byte),
        .i_start_of_response (i_start_of_response),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_kind              (o_kind),
        .o_byte_out          (o_byte_out),
        .o_status_code       (o_status_code),
        .o_body_length       (o_body_length),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data)
    );

    t_step_row dir_rows [DirRows] = '{
        '{1'b1, "H",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "T",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "T",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "P",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "/",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, " ",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "-",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "9",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "\n",  1'b1, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "H",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "T",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "T",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "P",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "/",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, " ",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "6",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "5",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "5",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "3",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "5",   1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "\n",  1'b1, KIND_ERROR,   16'd65535, 32'd0},
        '{1'b0, 8'hFF, 1'b1, KIND_IGNORED, 16'd65535, 32'd0},
        '{1'b1, "\r",  1'b0, KIND_HEADER,  16'd0,     32'd0},
        '{1'b0, "\n",  1'b1, KIND_HDR_END, 16'd0,     32'd0},
        '{1'b0, 8'h00, 1'b1, KIND_LAST,    16'd0,     32'd0},
        '{1'b0, "z",   1'b1, KIND_IGNORED, 16'd0,     32'd0}
    };

    logic [15:0] phase_threshold [Phases] = '{16'd0, 16'd65535, 16'd200, 16'd1, 16'd0, 16'd500};

    int      errors = 0;
    int      cycles = 0;
    int      beats_sent = 0;
    bit      calm = 1'b0;
    bit      hold_off_req = 1'b0;
    t_result pending_results [$];

    t_mode       mode;
    logic [4:0]  col;
    logic [2:0]  prefix_ok;
    logic        cut;
    logic        cr_first;
    t_sphase     st_phase;
    logic        st_neg;
    logic [15:0] st_acc;
    t_lphase     ln_phase;
    logic        ln_neg;
    logic [31:0] ln_acc;
    logic [15:0] got_status;
    logic [31:0] got_length;
    logic [31:0] body_seen;
    logic [15:0] threshold;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("http_response_header_parser_tb: errors");
            $finish;
        end
    end

    function automatic void clear_line();
        col = '0;
        prefix_ok = 3'b111;
        cut = 1'b0;
        cr_first = 1'b0;
        st_phase = SPH_PRE;
        st_neg = 1'b0;
        st_acc = '0;
        ln_phase = LPH_SKIP;
        ln_neg = 1'b0;
        ln_acc = '0;
    endfunction

    function automatic void clear_all();
        clear_line();
        mode = MODE_HEADER;
        got_status = '0;
        got_length = '0;
        body_seen = '0;
    endfunction

    function automatic t_result parse_byte(input logic [7:0] b, input logic sor);
        t_kind           k;
        logic            dig;
        logic            ws;
        logic [15:0]     st;
        longint unsigned wide;
        if (sor) begin
            clear_all();
        end
        k = KIND_IGNORED;
        if (mode == MODE_HEADER && b == 8'h0a) begin
            k = KIND_HEADER;
            if (prefix_ok[0] && col >= 5) begin
                st = st_neg ? 16'd0 : st_acc;
                got_status = st;
                if (st >= threshold) begin
                    mode = MODE_ERROR;
                    k = KIND_ERROR;
                end
            end else if (prefix_ok[2:1] != 2'b00 && col >= 15) begin
                got_length = ln_neg ? 32'd0 : ln_acc;
            end
            if (k != KIND_ERROR && cr_first) begin
                mode = MODE_BODY;
                k = KIND_HDR_END;
            end
            clear_line();
        end else if (mode == MODE_HEADER) begin
            k = KIND_HEADER;
            if (b == 8'h00) begin
                cut = 1'b1;
            end
            if (col < PfxShort) begin
                if (cut || b != HttpText[col]) prefix_ok[0] = 1'b0;
            end
            if (col < PfxLong) begin
                if (cut || b != LowerText[col]) prefix_ok[1] = 1'b0;
                if (cut || b != UpperText[col]) prefix_ok[2] = 1'b0;
            end
            if (col == 0 && b == 8'h0d) cr_first = 1'b1;
            if (col == 1 && b != 8'h00) cr_first = 1'b0;
            if (!cut) begin
                dig = b >= "0" && b <= "9";
                ws = b == " " || (b >= 8'd9 && b <= 8'd13);
                if (st_phase == SPH_PRE) begin
                    if (b == " ") st_phase = SPH_SKIP;
                end else if (st_phase == SPH_SKIP && ws) begin
                end else if (st_phase == SPH_SKIP && (b == "+" || b == "-")) begin
                    st_neg = b == "-";
                    st_phase = SPH_DIGITS;
                end else if (st_phase != SPH_DONE && dig) begin
                    wide = 64'(st_acc) * 10 + 64'(b[3:0]);
                    st_acc = wide > 64'd65535 ? 16'hFFFF : wide[15:0];
                    st_phase = SPH_DIGITS;
                end else begin
                    st_phase = SPH_DONE;
                end
                if (col >= 15) begin
                    if (ln_phase == LPH_SKIP && ws) begin
                    end else if (ln_phase == LPH_SKIP && (b == "+" || b == "-")) begin
                        ln_neg = b == "-";
                        ln_phase = LPH_DIGITS;
                    end else if (ln_phase != LPH_DONE && dig) begin
                        wide = 64'(ln_acc) * 10 + 64'(b[3:0]);
                        ln_acc = wide > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : wide[31:0];
                        ln_phase = LPH_DIGITS;
                    end else begin
                        ln_phase = LPH_DONE;
                    end
                end
            end
            if (col != 5'd31) col = col + 1'b1;
        end else if (mode == MODE_BODY) begin
            if (body_seen != 32'hFFFF_FFFF) body_seen = body_seen + 1;
            if (body_seen >= got_length) begin
                k = KIND_LAST;
                mode = MODE_DONE;
            end else begin
                k = KIND_BODY;
            end
        end
        return '{k, b, got_status, got_length};
    endfunction

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 16);
    endfunction

    function automatic string digit_run(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    task automatic flag_mismatch(input string what);
        errors++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("beat kind %0d byte %02h with nothing pending",
                                    o_kind, o_byte_out));
        end else begin
            want = pending_results.pop_front();
            if (o_kind != want.kind)
                flag_mismatch($sformatf("kind %0d, want %0d (byte %02h)",
                                        o_kind, want.kind, want.data));
            if (o_byte_out != want.data)
                flag_mismatch($sformatf("byte %02h, want %02h", o_byte_out, want.data));
            if (o_status_code != want.status)
                flag_mismatch($sformatf("status %0d, want %0d (byte %02h)",
                                        o_status_code, want.status, want.data));
            if (o_body_length != want.length)
                flag_mismatch($sformatf("length %0d, want %0d (byte %02h)",
                                        o_body_length, want.length, want.data));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic sor,
                             input logic given_ok, input t_result given);
        int      pause;
        t_result res;
        pause = calm ? 0 : pick_pause();
        if (pause > 0) begin
            i_in_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_start_of_response <= sor;
        do @(posedge i_clk); while (o_in_stall);
        res = parse_byte(b, sor);
        beats_sent++;
        pending_results.push_back(given_ok ? given : res);
    endtask

    task automatic send_text(input string s, input logic sor);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], sor && (i == 0), 1'b0, '0);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [15:0] v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        threshold = v;
    endtask

    task automatic send_response();
        int    pick;
        int    n;
        string s;
        string tail;
        logic  sor;
        sor = $urandom_range(0, 19) != 0;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)),
                          (i == 0 && sor) || $urandom_range(0, 15) == 0, 1'b0, '0);
            return;
        end
        s = ($urandom_range(0, 9) == 0) ? "HTTX/1.1" : "HTTP/1.1";
        tail = "";
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3, 4: s = {s, " ", $sformatf("%0d", $urandom_range(100, 599))};
            5: s = {s, " ", $sformatf("%0d", $urandom_range(0, 65535))};
            6: s = {s, " ", digit_run($urandom_range(6, 20))};
            7: s = {s, "  \t", ($urandom_range(0, 1) ? "-" : "+"),
                    $sformatf("%0d", $urandom_range(0, 999))};
            8: begin
            end
            default: begin
                s = {s, " 4"};
                tail = "04";
            end
        endcase
        send_text(s, sor);
        if (pick == 9) send_byte(8'h00, 1'b0, 1'b0, '0);
        send_text({tail, " OK\r\n"}, 1'b0);
        repeat ($urandom_range(0, 3)) begin
            pick = $urandom_range(0, 12);
            if (pick <= 6) begin
                s = $urandom_range(0, 1) ? "Content-Length:" : "content-length:";
                if ($urandom_range(0, 9) == 0) s.putc(8, "X");
                case ($urandom_range(0, 7))
                    0, 1, 2: s = {s, " ", $sformatf("%0d", $urandom_range(0, 12))};
                    3: s = {s, $sformatf("%0d", $urandom_range(0, 12))};
                    4: s = {s, " -", $sformatf("%0d", $urandom_range(0, 12))};
                    5: s = {s, " ", digit_run($urandom_range(8, 14))};
                    6: s = {s, "\t+", $sformatf("%0d", $urandom_range(0, 12)), "z9"};
                    default: begin
                        send_text({s, " 1"}, 1'b0);
                        send_byte(8'h00, 1'b0, 1'b0, '0);
                        s = "7";
                    end
                endcase
                send_text({s, "\r\n"}, 1'b0);
            end else if (pick <= 10) begin
                send_text({"X-Id: ", $sformatf("%0d", $urandom_range(0, 99999)), "\r\n"}, 1'b0);
            end else begin
                send_text({"Server: ", digit_run(30), "\r\n"}, 1'b0);
            end
        end
        case ($urandom_range(0, 9))
            0: send_text("\n", 1'b0);
            1: begin
                send_byte("\r", 1'b0, 1'b0, '0);
                send_byte(8'h00, 1'b0, 1'b0, '0);
                send_byte("\n", 1'b0, 1'b0, '0);
            end
            2: send_text("\rx\n", 1'b0);
            default: send_text("\r\n", 1'b0);
        endcase
        if (mode == MODE_BODY)
            n = (got_length <= 32'd40) ? int'(got_length) : $urandom_range(1, 8);
        else
            n = 0;
        n = n + $urandom_range(0, 3);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    endtask

    initial begin
        int          stall_left;
        bit          hold_off_done;
        stall_left = 0;
        hold_off_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) check_result();
            if (stall_left == 0) begin
                if (hold_off_req && !hold_off_done) begin
                    stall_left = 80;
                    hold_off_done = 1'b1;
                end else if (!calm) begin
                    stall_left = pick_pause();
                end
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        clear_all();
        threshold = StatusMinReset;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < DirRows; i++)
            send_byte(dir_rows[i].data, dir_rows[i].sor, dir_rows[i].typed,
                      t_result'{dir_rows[i].kind, dir_rows[i].data,
                                dir_rows[i].status, dir_rows[i].length});
        for (int ph = 0; ph < Phases; ph++) begin
            set_threshold(ph == 4 ? 16'($urandom_range(100, 600)) : phase_threshold[ph]);
            calm = (ph == 2);
            if (ph == 3) hold_off_req = 1'b1;
            beats_sent = 0;
            while (beats_sent < PhaseBeats) send_response();
        end
        wait_idle();
        if (errors == 0) begin
            $display("http_response_header_parser_tb: clean");
        end else begin
            $display("http_response_header_parser_tb: errors");
        end
        $finish;
    end

endmodule
